FILE: rtl/bsc_pkg.sv
// Package for the banker's safety check block: item types, codes and sizes.
// Used by bsc_ctrl, bsc_datapath and bankers_safety_check_with_recovery.
package bsc_pkg;

    localparam int unsigned PROCS_DEF = 8;
    localparam int unsigned RES_DEF   = 4;
    localparam logic [9:0]  CLAIM_MAX = 10'd1023;
    localparam logic [11:0] AVAIL_MAX = 12'd4095;

    typedef enum logic [1:0] {
        K_WR_ALLOC = 2'd0,
        K_WR_CLAIM = 2'd1,
        K_WR_AVAIL = 2'd2,
        K_RUN      = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        R_SAFE  = 2'd0,
        R_REMOV = 2'd1,
        R_STUCK = 2'd2,
        R_ACK   = 2'd3
    } t_rkind;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] proc_index;
        logic [1:0] res_index;
        logic [7:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [2:0] proc_id;
        logic       last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write;      // apply the table write from the input item
        logic init;       // copy available to working vector, clear finished mask
        logic scan;       // examine process at scan pointer
        logic commit;     // finish the process at the scan pointer
        logic sum_step;   // compare need sum of process at scan pointer with the least so far
        logic remove;     // recover the chosen process
        logic ptr_clr;    // reset the scan pointer and least-need search
        logic ptr_inc;    // advance the scan pointer
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fits;       // process at pointer is unfinished and fits
        logic ptr_last;   // pointer is at the last process
        logic all_done;   // every process finished
    } t_stat;

endpackage

FILE: rtl/bsc_datapath.sv
// Datapath of the banker's safety check: tables, working vector, search logic.
// Depends on bsc_pkg; driven by bsc_ctrl.
module bsc_datapath
    import bsc_pkg::*;
#(
    parameter int unsigned PROCS = PROCS_DEF,
    parameter int unsigned RES   = RES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_in_item                 i_item,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    output logic [$clog2(PROCS)-1:0] o_ptr,
    output logic [$clog2(PROCS)-1:0] o_best,
    output logic [$clog2(PROCS)-1:0] o_first_unfin
);
    localparam int unsigned PW = (PROCS > 1) ? $clog2(PROCS) : 1;
    localparam int unsigned RW = (RES > 1) ? $clog2(RES) : 1;
    localparam int unsigned SW = 14;

    logic [7:0]  r_alloc [PROCS][RES];
    logic [9:0]  r_claim [PROCS][RES];
    logic [11:0] r_avail [RES];
    logic [11:0] r_work  [RES];
    logic [PROCS-1:0] r_fin;
    logic [PW-1:0] r_ptr;
    logic [PW-1:0] r_best;
    logic [SW-1:0] r_best_sum;

    logic [9:0]    need   [RES];
    logic          fits_all;
    logic [SW-1:0] sum;
    logic [PW-1:0] first_unfin;

    always_comb begin
        fits_all = 1'b1;
        sum      = '0;
        for (int r = 0; r < RES; r++) begin
            need[r] = (r_claim[r_ptr][r] > {2'b00, r_alloc[r_ptr][r]})
                    ? r_claim[r_ptr][r] - {2'b00, r_alloc[r_ptr][r]} : 10'd0;
            if ({2'b00, need[r]} > r_work[r]) begin
                fits_all = 1'b0;
            end
            sum = sum + SW'(need[r]);
        end
        first_unfin = '0;
        for (int p = PROCS - 1; p >= 0; p--) begin
            if (!r_fin[p]) begin
                first_unfin = PW'(p);
            end
        end
    end

    assign o_stat.fits     = fits_all && !r_fin[r_ptr];
    assign o_stat.ptr_last = (r_ptr == PW'(PROCS - 1));
    assign o_stat.all_done = &r_fin;
    assign o_ptr           = r_ptr;
    assign o_best          = r_best;
    assign o_first_unfin   = first_unfin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PROCS; p++) begin
                for (int r = 0; r < RES; r++) begin
                    r_alloc[p][r] <= '0;
                    r_claim[p][r] <= '0;
                end
            end
            for (int r = 0; r < RES; r++) begin
                r_avail[r] <= '0;
                r_work[r]  <= '0;
            end
            r_fin      <= '0;
            r_ptr      <= '0;
            r_best     <= '0;
            r_best_sum <= '0;
        end else begin
            if (i_cmd.write && (32'(i_item.res_index) < RES)) begin
                if (i_item.kind == K_WR_AVAIL) begin
                    r_avail[RW'(i_item.res_index)] <= {4'd0, i_item.value};
                end else if (32'(i_item.proc_index) < PROCS) begin
                    if (i_item.kind == K_WR_ALLOC) begin
                        r_alloc[PW'(i_item.proc_index)][RW'(i_item.res_index)]
                            <= i_item.value;
                    end else if (i_item.kind == K_WR_CLAIM) begin
                        r_claim[PW'(i_item.proc_index)][RW'(i_item.res_index)]
                            <= {2'b00, i_item.value};
                    end
                end
            end
            if (i_cmd.init) begin
                for (int r = 0; r < RES; r++) begin
                    r_work[r] <= r_avail[r];
                end
                r_fin <= '0;
            end
            if (i_cmd.commit) begin
                for (int r = 0; r < RES; r++) begin
                    r_work[r] <= ({1'b0, r_work[r]} + 13'(r_alloc[r_ptr][r]) > 13'(AVAIL_MAX))
                               ? AVAIL_MAX : r_work[r] + 12'(r_alloc[r_ptr][r]);
                end
                r_fin[r_ptr] <= 1'b1;
            end
            if (i_cmd.sum_step) begin
                if (r_ptr == '0 || sum < r_best_sum) begin
                    r_best_sum <= sum;
                    r_best     <= r_ptr;
                end
            end
            if (i_cmd.remove) begin
                for (int r = 0; r < RES; r++) begin
                    r_avail[r] <= ({1'b0, r_avail[r]} + 13'(r_alloc[r_best][r]) > 13'(AVAIL_MAX))
                                ? AVAIL_MAX : r_avail[r] + 12'(r_alloc[r_best][r]);
                    r_claim[r_best][r] <= ({1'b0, r_claim[r_best][r]}
                                          + 11'(r_alloc[r_best][r]) > 11'(CLAIM_MAX))
                                        ? CLAIM_MAX : r_claim[r_best][r] + 10'(r_alloc[r_best][r]);
                    r_alloc[r_best][r] <= '0;
                end
            end
            if (i_cmd.ptr_clr) begin
                r_ptr <= '0;
            end else if (i_cmd.ptr_inc) begin
                r_ptr <= r_ptr + 1'b1;
            end
        end
    end
endmodule

FILE: rtl/bsc_ctrl.sv
// Controller state machine of the banker's safety check.
// Depends on bsc_pkg; commands bsc_datapath.
module bsc_ctrl
    import bsc_pkg::*;
#(
    parameter int unsigned PROCS = PROCS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  t_kind                    i_kind,
    input  t_stat                    i_stat,
    input  logic [$clog2(PROCS)-1:0] i_ptr,
    input  logic [$clog2(PROCS)-1:0] i_best,
    input  logic [$clog2(PROCS)-1:0] i_first_unfin,
    input  logic [2:0]               i_proc_index,
    output t_cmd                     o_cmd,
    output logic                     o_busy,
    output logic                     o_valid,
    output t_out_item                o_result
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_INIT  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_JUDGE = 7'b0001000,
        S_SUM   = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_REMV  = 7'b1000000
    } t_state;

    localparam int unsigned CW = $clog2(PROCS + 1);
    localparam int unsigned PW = $clog2(PROCS);

    t_state r_state, n_state;
    logic [CW-1:0] r_pass, n_pass;
    logic [CW-1:0] r_rem, n_rem;
    logic [PW-1:0] r_order [PROCS];
    logic [PW-1:0] r_ocnt;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_pass   = r_pass;
        n_rem    = r_rem;
        o_cmd    = '0;
        o_valid  = 1'b0;
        o_result = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_kind == K_RUN) begin
                        n_state = S_INIT;
                        n_rem   = '0;
                    end else begin
                        o_cmd.write          = 1'b1;
                        o_valid              = 1'b1;
                        o_result.result_kind = R_ACK;
                        o_result.proc_id     = i_proc_index;
                        o_result.last        = 1'b1;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init    = 1'b1;
                o_cmd.ptr_clr = 1'b1;
                n_pass        = '0;
                n_state       = S_SCAN;
            end
            S_SCAN: begin
                // One pass finds the lowest-index process that fits.
                if (i_stat.fits) begin
                    o_cmd.commit  = 1'b1;
                    o_cmd.ptr_clr = 1'b1;
                    n_pass        = r_pass + 1'b1;
                    if (r_pass == CW'(PROCS - 1)) begin
                        n_state = S_JUDGE;
                    end
                end else if (i_stat.ptr_last) begin
                    o_cmd.ptr_clr = 1'b1;
                    n_state       = S_JUDGE;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            S_JUDGE: begin
                o_cmd.ptr_clr = 1'b1;
                if (i_stat.all_done) begin
                    n_state = S_EMIT;
                end else if (r_rem == CW'(PROCS)) begin
                    o_valid              = 1'b1;
                    o_result.result_kind = R_STUCK;
                    o_result.proc_id     = 3'(i_first_unfin);
                    o_result.last        = 1'b1;
                    n_state              = S_IDLE;
                end else begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_stat.ptr_last) begin
                    n_state = S_REMV;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            S_REMV: begin
                o_cmd.remove         = 1'b1;
                o_valid              = 1'b1;
                o_result.result_kind = R_REMOV;
                o_result.proc_id     = 3'(i_best);
                n_rem                = r_rem + 1'b1;
                n_state              = S_INIT;
            end
            S_EMIT: begin
                o_valid              = 1'b1;
                o_result.result_kind = R_SAFE;
                o_result.proc_id     = 3'(r_order[i_ptr]);
                if (i_stat.ptr_last) begin
                    o_result.last = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= '0;
            r_rem   <= '0;
            r_ocnt  <= '0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
            r_rem   <= n_rem;
            if (r_state == S_INIT) begin
                r_ocnt <= '0;
            end else if (o_cmd.commit) begin
                r_ocnt <= r_ocnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd.commit) begin
            r_order[r_ocnt] <= i_ptr;
        end
    end
endmodule

FILE: rtl/bankers_safety_check_with_recovery.sv
// Top level of the banker's safety check with deadlock recovery.
// Depends on bsc_pkg, bsc_ctrl and bsc_datapath.
//
// Write items (allocation, claim, available) are acknowledged in the same
// cycle in which they are taken, so writes can arrive back to back. A run
// item holds busy while the controller walks the process rows one per cycle:
// each safety check loads the working vector, scans the rows and judges the
// result, each recovery runs a least-need search over all rows and removes
// the chosen process, and a safe order is output process by process.
// Results appear with o_valid for a single cycle and the receiver cannot
// stall them; proc_id is the process concerned and last marks the final
// result of the item.
module bankers_safety_check_with_recovery
    import bsc_pkg::*;
#(
    parameter int unsigned PROCS = PROCS_DEF,
    parameter int unsigned RES   = RES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_valid,
    output t_out_item o_result
);
    localparam int unsigned PW = $clog2(PROCS);

    t_cmd          cmd;
    t_stat         stat;
    logic [PW-1:0] ptr, best, first_unfin;

    // The controller sequences checks and recovery; the datapath holds tables.
    bsc_ctrl #(.PROCS(PROCS)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_kind        (t_kind'(i_item.kind)),
        .i_stat        (stat),
        .i_ptr         (ptr),
        .i_best        (best),
        .i_first_unfin (first_unfin),
        .i_proc_index  (i_item.proc_index),
        .o_cmd         (cmd),
        .o_busy        (busy),
        .o_valid       (o_valid),
        .o_result      (o_result)
    );

    bsc_datapath #(.PROCS(PROCS), .RES(RES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (i_item),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_ptr         (ptr),
        .o_best        (best),
        .o_first_unfin (first_unfin)
    );
endmodule
